// ===== src/m9pt_pkg.sv =====
// ----------------------------------------------------------------------------
// m9pt_pkg: shared types and constants of the median-of-9 peak tracker
// Word sizes, group size and the exchange order of the median compare network.
// ----------------------------------------------------------------------------
`default_nettype none

package m9pt_pkg;

  localparam int GROUP_SIZE = 9;
  localparam int NUM_EXCH   = 19;
  localparam int WORD_BITS  = 16;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [3:0]           slot_t;   // index into one group of nine

  localparam word_t WORD_ONES       = '1;
  localparam word_t THRESHOLD_RESET = 16'd199;

  // compare-exchange pairs in network order, the EXCH_LO slot keeps the smaller value
  localparam slot_t EXCH_LO [NUM_EXCH] = '{
    4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
    4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4
  };
  localparam slot_t EXCH_HI [NUM_EXCH] = '{
    4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
    4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2
  };

  localparam slot_t MEDIAN_SLOT = 4'd4;

endpackage

`default_nettype wire

// ===== src/median9_block_peak_tracker_top.sv =====
// ----------------------------------------------------------------------------
// median9_block_peak_tracker_top: median-of-9 filter with windowed peak tracking
// Groups converter samples by nine, takes each group's median and keeps the
// max, min and count of medians over tick-based windows.
// ----------------------------------------------------------------------------
// Each input beat is either a converter sample (mode 0) or a one millisecond
// tick (mode 1), and each one gives exactly one result beat. The block takes
// one beat per clock while the result channel is not stalled; each beat goes
// through the input register, then the result register. The cycle time is set by the
// median compare network plus the running max/min compare, which sit between
// the two registers. The ninth sample of each disjoint group reports the
// group median; a tick whose elapsed count passes window_threshold latches the
// running max, min and count of medians and restarts them. The window fields
// of every result beat show the last latched window. The user must write the
// threshold register over the cfg channel while no beat is in flight (not enforced).
`default_nettype none

module median9_block_peak_tracker_top #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  // input channel
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            mode,
  input  m9pt_pkg::word_t sample,
  // result channel
  output logic            out_valid,
  input  logic            out_ready,
  output logic            median_ready,
  output m9pt_pkg::word_t median_value,
  output logic            window_closed,
  output m9pt_pkg::word_t window_max,
  output m9pt_pkg::word_t window_min,
  output m9pt_pkg::word_t window_count,
  // threshold write channel
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  m9pt_pkg::word_t cfg_data
);

  import m9pt_pkg::*;

  localparam int BUF_DEPTH    = GROUP_SIZE - 1;
  localparam int BUF_IDX_BITS = $clog2(BUF_DEPTH);
  localparam slot_t LAST_SLOT = slot_t'(GROUP_SIZE - 1);

  typedef logic [SAMPLE_BITS-1:0] samp_t;

  // handshake
  logic  in_fire;
  logic  a_fire;
  logic  out_load;

  // first eight samples of the group being filled
  samp_t group_buffer [BUF_DEPTH];
  slot_t group_fill;

  // input register stage
  logic  a_valid;
  logic  a_mode;
  logic  a_last;
  samp_t a_sample;

  // running and latched window state
  word_t window_threshold;
  word_t elapsed_ticks;
  word_t running_max;
  word_t running_min;
  word_t running_count;
  word_t latched_max;
  word_t latched_min;
  word_t latched_count;

  // second stage logic
  samp_t net_vals [GROUP_SIZE];
  samp_t net_median;
  word_t med_word;
  word_t ticks_inc;
  logic  med_hit;
  logic  win_close;

  // ---------------------------------------------------------------------------
  // handshake: the result register frees the input register, which frees input
  // ---------------------------------------------------------------------------
  assign out_load  = !out_valid || out_ready;
  assign a_fire    = a_valid && out_load;
  assign in_ready  = !a_valid || out_load;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // stage one: fill the group buffer, flag the sample that completes a group
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      group_fill <= '0;
    end else begin
      if (in_fire) begin
        a_valid <= 1'b1;
        if (!mode) begin
          // ninth sample goes straight to stage two, slot wraps to zero
          group_fill <= (group_fill == LAST_SLOT) ? '0 : group_fill + slot_t'(1);
        end
      end else if (a_fire) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_mode   <= mode;
      a_sample <= sample[SAMPLE_BITS-1:0];
      a_last   <= !mode && (group_fill == LAST_SLOT);
      if (!mode && group_fill != LAST_SLOT) begin
        group_buffer[group_fill[BUF_IDX_BITS-1:0]] <= sample[SAMPLE_BITS-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage two: median of the completed group, window bookkeeping
  // the buffer only changes when stage two advances, so it is read in place
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      net_vals[i] = group_buffer[i];
    end
    net_vals[GROUP_SIZE-1] = a_sample;
  end

  m9pt_median #(
    .W (SAMPLE_BITS)
  ) u_median (
    .vals   (net_vals),
    .median (net_median)
  );

  assign med_word  = word_t'(net_median);
  assign med_hit   = !a_mode && a_last;
  // tick counter saturates, so a full-scale threshold never closes the window
  assign ticks_inc = (elapsed_ticks == WORD_ONES) ? elapsed_ticks
                                                  : elapsed_ticks + word_t'(1);
  assign win_close = a_mode && (ticks_inc > window_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_threshold <= THRESHOLD_RESET;
      elapsed_ticks    <= '0;
      running_max      <= '0;
      running_min      <= WORD_ONES;
      running_count    <= '0;
      latched_max      <= '0;
      latched_min      <= WORD_ONES;
      latched_count    <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_threshold <= cfg_data;
      end
      if (a_fire) begin
        if (a_mode) begin
          elapsed_ticks <= win_close ? '0 : ticks_inc;
          if (win_close) begin
            latched_max   <= running_max;
            latched_min   <= running_min;
            latched_count <= running_count;
            running_max   <= '0;
            running_min   <= WORD_ONES;
            running_count <= '0;
          end
        end else if (med_hit) begin
          // count saturates at full scale
          if (running_count != WORD_ONES) begin
            running_count <= running_count + word_t'(1);
          end
          if (running_max < med_word) begin
            running_max <= med_word;
          end
          if (running_min > med_word) begin
            running_min <= med_word;
          end
        end
      end
      if (a_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result beat payload, window fields show the latched window or the one closing now
  always_ff @(posedge clk) begin
    if (a_fire) begin
      median_ready  <= med_hit;
      median_value  <= med_hit ? med_word : '0;
      window_closed <= win_close;
      window_max    <= win_close ? running_max   : latched_max;
      window_min    <= win_close ? running_min   : latched_min;
      window_count  <= win_close ? running_count : latched_count;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_median_xor_window: assert property (@(posedge clk) disable iff (rst)
    out_valid && median_ready |-> !window_closed)
    else $error("median and window close on one beat");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> a_valid && out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  a_window_restart: assert property (@(posedge clk) disable iff (rst)
    a_fire && win_close |=> elapsed_ticks == '0 && running_count == '0
                            && running_max == '0 && running_min == WORD_ONES)
    else $error("window state not restarted after close");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    group_fill <= LAST_SLOT)
    else $error("group fill out of range");

endmodule

`default_nettype wire

// ===== src/m9pt_median.sv =====
// ----------------------------------------------------------------------------
// m9pt_median: median of nine words
// Combinational 19-exchange compare network, nine compare levels deep.
// ----------------------------------------------------------------------------
`default_nettype none

module m9pt_median #(
  parameter int W = 16
) (
  input  logic [W-1:0] vals [m9pt_pkg::GROUP_SIZE],
  output logic [W-1:0] median
);

  import m9pt_pkg::*;

  logic [W-1:0] v [GROUP_SIZE];
  logic [W-1:0] lo_val;
  logic [W-1:0] hi_val;

  always_comb begin
    v = vals;
    for (int k = 0; k < NUM_EXCH; k++) begin
      lo_val = v[EXCH_LO[k]];
      hi_val = v[EXCH_HI[k]];
      if (lo_val > hi_val) begin
        v[EXCH_LO[k]] = hi_val;
        v[EXCH_HI[k]] = lo_val;
      end
    end
    median = v[MEDIAN_SLOT];
  end

endmodule

`default_nettype wire
